>>> sv/svsu_pkg.sv
package svsu_pkg;

  // default geometry
  localparam int DEF_SCALE         = 3;
  localparam int DEF_SOURCE_WIDTH  = 256;
  localparam int DEF_OUTPUT_HEIGHT = 720;
  localparam int DEF_OUTPUT_WIDTH  = 768;

  // frame buffer
  localparam int RAM_DEPTH  = 16384;
  localparam int RAM_ADDR_W = 14;
  localparam int BYTE_W     = 8;

  // output coordinates and colors
  localparam int COORD_W = 10;
  localparam int COLOR_W = 24;
  localparam int NUM_COLORS = 4;

  // apb
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // palette reset values
  localparam logic [COLOR_W-1:0] PAL0_RESET = 24'h000000;
  localparam logic [COLOR_W-1:0] PAL1_RESET = 24'hC00000;
  localparam logic [COLOR_W-1:0] PAL2_RESET = 24'h00C000;
  localparam logic [COLOR_W-1:0] PAL3_RESET = 24'h0060FF;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } opcode_t;

  typedef logic [NUM_COLORS-1:0][COLOR_W-1:0] palette_t;

  // current scan position as seen by the datapath
  typedef struct packed {
    logic [RAM_ADDR_W-1:0] addr;
    logic [1:0]            sub;
    logic [COORD_W-1:0]    x;
    logic [COORD_W-1:0]    y;
    logic                  last;
  } scan_info_t;

endpackage

>>> sv/svsu_ram.sv
module svsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/svsu_scan.sv
module svsu_scan #(
  parameter int SCALE         = svsu_pkg::DEF_SCALE,
  parameter int SOURCE_WIDTH  = svsu_pkg::DEF_SOURCE_WIDTH,
  parameter int OUTPUT_HEIGHT = svsu_pkg::DEF_OUTPUT_HEIGHT,
  parameter int OUTPUT_WIDTH  = svsu_pkg::DEF_OUTPUT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  output svsu_pkg::scan_info_t   info
);

  localparam int EFF_SCALE = (SCALE > 0) ? SCALE : 1;
  localparam int PW = (EFF_SCALE > 1) ? $clog2(EFF_SCALE) : 1;
  localparam int CW = (OUTPUT_WIDTH > 1) ? $clog2(OUTPUT_WIDTH) : 1;
  localparam int RW = (OUTPUT_HEIGHT > 1) ? $clog2(OUTPUT_HEIGHT) : 1;
  localparam int BW = svsu_pkg::RAM_ADDR_W + 2;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [PW-1:0] xph;
  logic [PW-1:0] yph;
  logic [CW-1:0] src_x;
  logic [BW-1:0] row_base;

  logic          col_end;
  logic          row_end;
  logic [BW-1:0] addr_full;
  logic [CW+svsu_pkg::COORD_W-1:0] col_ext;
  logic [RW+svsu_pkg::COORD_W-1:0] row_ext;

  assign col_end   = (col == CW'(OUTPUT_WIDTH - 1));
  assign row_end   = (row == RW'(OUTPUT_HEIGHT - 1));
  assign addr_full = row_base + BW'(src_x);
  assign col_ext   = {{svsu_pkg::COORD_W{1'b0}}, col};
  assign row_ext   = {{svsu_pkg::COORD_W{1'b0}}, row};

  always_comb begin
    info.addr = addr_full[BW-1:2];
    info.sub  = src_x[1:0];
    info.x    = col_ext[svsu_pkg::COORD_W-1:0];
    info.y    = row_ext[svsu_pkg::COORD_W-1:0];
    info.last = col_end && row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      xph      <= '0;
      yph      <= '0;
      src_x    <= '0;
      row_base <= '0;
    end else if (step) begin
      if (col_end) begin
        col   <= '0;
        xph   <= '0;
        src_x <= '0;
        if (row_end) begin
          row      <= '0;
          yph      <= '0;
          row_base <= '0;
        end else begin
          row <= row + RW'(1);
          if (yph == PW'(EFF_SCALE - 1)) begin
            yph      <= '0;
            row_base <= row_base + BW'(SOURCE_WIDTH);
          end else begin
            yph <= yph + PW'(1);
          end
        end
      end else begin
        col <= col + CW'(1);
        if (xph == PW'(EFF_SCALE - 1)) begin
          xph   <= '0;
          src_x <= src_x + CW'(1);
        end else begin
          xph <= xph + PW'(1);
        end
      end
    end
  end

endmodule

>>> sv/svsu_palette.sv
module svsu_palette (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [svsu_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [svsu_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [svsu_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output svsu_pkg::palette_t                 palette
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[3:2];
  assign prdata = {{(svsu_pkg::APB_DATA_W - svsu_pkg::COLOR_W){1'b0}}, palette[idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      palette[0] <= svsu_pkg::PAL0_RESET;
      palette[1] <= svsu_pkg::PAL1_RESET;
      palette[2] <= svsu_pkg::PAL2_RESET;
      palette[3] <= svsu_pkg::PAL3_RESET;
    end else if (wr) begin
      palette[idx] <= pwdata[svsu_pkg::COLOR_W-1:0];
    end
  end

endmodule

>>> sv/scaled_2bpp_video_scanout_unit.sv
// scaled 2-bit-per-pixel video scan-out
//
// input stream (s_*): one item per transfer. s_tuser is the opcode. a write
// item stores s_tdata[21:14] at frame buffer byte offset s_tdata[13:0] and
// gives no output. a tick item emits the pixel at the current raster position
// and then advances the scan (left to right, top to bottom, wraps at frame end)
// output stream (m_*): x, y and 24-bit palette color in m_tdata, m_tlast on
// the last pixel of a frame
// apb port: four palette registers at byte addresses 0, 4, 8, 12
//
// throughput is one item per clock outside the sweep and while the output does not stall: the
// frame buffer ram takes one write or one read per cycle and the scan counters step once per tick
// a tick passes the read stage, where the ram read is registered at its transfer edge, and then
// the output register, where the palette lookup is registered and which drives m_tvalid
// after reset the frame buffer is swept to zero, one byte a cycle, over all 16384
// bytes; s_tready stays low during the sweep (apb writes still work)
// when the receiver stalls the output register and the read stage both hold,
// and s_tready drops once both are full
module scaled_2bpp_video_scanout_unit #(
  parameter int SCALE         = svsu_pkg::DEF_SCALE,
  parameter int SOURCE_WIDTH  = svsu_pkg::DEF_SOURCE_WIDTH,
  parameter int OUTPUT_HEIGHT = svsu_pkg::DEF_OUTPUT_HEIGHT,
  parameter int OUTPUT_WIDTH  = svsu_pkg::DEF_OUTPUT_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  // apb configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [svsu_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [svsu_pkg::APB_DATA_W-1:0] pwdata,
  output logic [svsu_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [23:0]                     s_tdata,  // buffer_offset[13:0], write_byte[21:14]
  input  logic                            s_tuser,  // opcode
  // output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [47:0]                     m_tdata,  // pixel_x[9:0], pixel_y[19:10], pixel_color[43:20]
  output logic                            m_tlast   // frame_last
);

  localparam int AW = svsu_pkg::RAM_ADDR_W;
  localparam int XW = svsu_pkg::COORD_W;
  localparam int LAST_X = (OUTPUT_WIDTH - 1) % 1024;

  // clearing sweep
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // item decode
  logic accept;
  logic acc_tick;
  logic acc_write;

  // scan position
  svsu_pkg::scan_info_t info;

  // ram ports
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [svsu_pkg::BYTE_W-1:0] ram_wdata;
  logic [svsu_pkg::BYTE_W-1:0] ram_rdata;

  // read stage
  logic          v1;
  logic [1:0]    sub1;
  logic [XW-1:0] x1;
  logic [XW-1:0] y1;
  logic          last1;
  logic          adv1;
  logic [1:0]    code;

  // output register
  logic                          ov;
  logic [XW-1:0]                 out_x;
  logic [XW-1:0]                 out_y;
  logic [svsu_pkg::COLOR_W-1:0]  out_color;
  logic                          out_last;

  svsu_pkg::palette_t palette;

  assign adv1      = v1 && (!ov || m_tready);
  assign s_tready  = !clearing && (!v1 || adv1);
  assign accept    = s_tvalid && s_tready;
  assign acc_tick  = accept && (s_tuser == svsu_pkg::OP_TICK);
  assign acc_write = accept && (s_tuser == svsu_pkg::OP_WRITE);

  // sweep writes zeros, otherwise item writes go straight in
  assign ram_we    = clearing || acc_write;
  assign ram_waddr = clearing ? clr_addr : s_tdata[AW-1:0];
  assign ram_wdata = clearing ? '0 : s_tdata[AW+svsu_pkg::BYTE_W-1:AW];

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == {AW{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  svsu_scan #(
    .SCALE        (SCALE),
    .SOURCE_WIDTH (SOURCE_WIDTH),
    .OUTPUT_HEIGHT(OUTPUT_HEIGHT),
    .OUTPUT_WIDTH (OUTPUT_WIDTH)
  ) u_scan (
    .clk (clk),
    .rst (rst),
    .step(acc_tick),
    .info(info)
  );

  // frame buffer, read once per tick
  svsu_ram #(
    .WIDTH(svsu_pkg::BYTE_W),
    .DEPTH(svsu_pkg::RAM_DEPTH)
  ) u_fb (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (acc_tick),
    .raddr(info.addr),
    .rdata(ram_rdata)
  );

  svsu_palette u_pal (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .palette(palette)
  );

  // read stage: ram data lands here together with the position
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (acc_tick) begin
      v1 <= 1'b1;
    end else if (adv1) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_tick) begin
      sub1  <= info.sub;
      x1    <= info.x;
      y1    <= info.y;
      last1 <= info.last;
    end
  end

  // leftmost pixel in the top bits
  always_comb begin
    case (sub1)
      2'd0:    code = ram_rdata[7:6];
      2'd1:    code = ram_rdata[5:4];
      2'd2:    code = ram_rdata[3:2];
      2'd3:    code = ram_rdata[1:0];
      default: code = ram_rdata[7:6];
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv1) begin
      ov <= 1'b1;
    end else if (m_tready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      out_x     <= x1;
      out_y     <= y1;
      out_color <= palette[code];
      out_last  <= last1;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {4'b0, out_color, out_y, out_x};
  assign m_tlast  = out_last;

  // no transfer while the sweep runs
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("input accepted during frame buffer sweep");

  // a tick always reaches the read stage
  a_tick_enters: assert property (@(posedge clk) disable iff (rst)
    acc_tick |=> v1)
    else $error("tick lost before read stage");

  // a blocked read stage keeps its item
  a_read_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (v1 && ov && !m_tready) |=> v1)
    else $error("read stage dropped an item under stall");

  // frame end flag only at the last column
  a_last_column: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[9:0] == XW'(LAST_X)))
    else $error("frame end flag away from last column");

endmodule

>>> bench/scaled_2bpp_video_scanout_unit_test.sv
import svsu_pkg::*;

typedef enum int {
  PAL_COLOR0,
  PAL_COLOR1,
  PAL_COLOR2,
  PAL_COLOR3
} palette_reg_e;

class raster_scoreboard;
  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               frame_end;
  } pixel_t;

  logic [BYTE_W-1:0]  frame_ram [RAM_DEPTH];
  logic [COLOR_W-1:0] palette   [NUM_COLORS];
  int unsigned        scan_col;
  int unsigned        scan_row;
  pixel_t             pending_pixels [$];
  int unsigned        failures;
  int unsigned        shown;

  function void clear();
    foreach (frame_ram[i]) frame_ram[i] = '0;
    palette[0] = PAL0_RESET;
    palette[1] = PAL1_RESET;
    palette[2] = PAL2_RESET;
    palette[3] = PAL3_RESET;
    scan_col = 0;
    scan_row = 0;
    pending_pixels.delete();
    failures = 0;
    shown = 0;
  endfunction

  function void flag(string what, longint unsigned want, longint unsigned got);
    failures++;
    if (shown < 10) begin
      $display("%s mismatch: expected %0h, got %0h", what, want, got);
      shown++;
    end
  endfunction

  // frame buffer byte that holds the source pixel under an output position
  function logic [RAM_ADDR_W-1:0] source_offset(int unsigned col, int unsigned row);
    int unsigned sx;
    int unsigned sy;
    sx = col / DEF_SCALE;
    sy = row / DEF_SCALE;
    return RAM_ADDR_W'((sy * DEF_SOURCE_WIDTH + sx) >> 2);
  endfunction

  function int unsigned scan_pos();
    return scan_row * DEF_OUTPUT_WIDTH + scan_col;
  endfunction

  function logic [RAM_ADDR_W-1:0] upcoming_offset(int unsigned ahead);
    int unsigned pos;
    pos = (scan_pos() + ahead) % (DEF_OUTPUT_WIDTH * DEF_OUTPUT_HEIGHT);
    return source_offset(pos % DEF_OUTPUT_WIDTH, pos / DEF_OUTPUT_WIDTH);
  endfunction

  function void set_color(palette_reg_e idx, logic [APB_DATA_W-1:0] value);
    palette[idx] = value[COLOR_W-1:0];
  endfunction

  function void check_register(palette_reg_e idx, logic [APB_DATA_W-1:0] data);
    if (data !== APB_DATA_W'(palette[idx])) flag("palette readback", palette[idx], data);
  endfunction

  // one accepted input transfer: a write updates the buffer, a tick predicts a pixel
  function void note_transfer(opcode_t op, logic [23:0] data);
    logic [BYTE_W-1:0] byte_val;
    logic [1:0]        code;
    int unsigned       sx;
    pixel_t            px;
    if (op == OP_WRITE) begin
      frame_ram[data[13:0]] = data[21:14];
    end else begin
      sx = scan_col / DEF_SCALE;
      byte_val = frame_ram[source_offset(scan_col, scan_row)];
      code = byte_val[2 * (3 - sx % 4) +: 2];
      px.x = COORD_W'(scan_col);
      px.y = COORD_W'(scan_row);
      px.color = palette[code];
      px.frame_end = (scan_col >= DEF_OUTPUT_WIDTH - 1) && (scan_row >= DEF_OUTPUT_HEIGHT - 1);
      pending_pixels.push_back(px);
      if (scan_col >= DEF_OUTPUT_WIDTH - 1) begin
        scan_col = 0;
        scan_row = (scan_row >= DEF_OUTPUT_HEIGHT - 1) ? 0 : scan_row + 1;
      end else begin
        scan_col++;
      end
    end
  endfunction

  function void check_pixel(logic [47:0] data, logic frame_end);
    pixel_t want;
    if (pending_pixels.size() == 0) begin
      flag("pixel with none pending", 0, data);
    end else begin
      want = pending_pixels.pop_front();
      if (data[9:0] !== want.x) flag("pixel_x", want.x, data[9:0]);
      if (data[19:10] !== want.y) flag("pixel_y", want.y, data[19:10]);
      if (data[43:20] !== want.color) flag("pixel_color", want.color, data[43:20]);
      if (frame_end !== want.frame_end) flag("frame_last", want.frame_end, frame_end);
    end
  endfunction

  function void finish();
    failures += pending_pixels.size();
  endfunction
endclass

module scaled_2bpp_video_scanout_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // bytes actually shown at the default geometry (240 source rows of 64 bytes)
  localparam int VISIBLE_BYTES   = (DEF_OUTPUT_HEIGHT / DEF_SCALE) * (DEF_SOURCE_WIDTH / 4);
  // ticks sent back to back in the full-rate run
  localparam int FULL_RATE_TICKS = 200;
  // two-stage pipeline plus margin, waited out after the last pixel
  localparam int SETTLE_CYCLES   = 6;
  // clearing sweep + all items under the sparsest receiver, several times over
  localparam int CYCLE_LIMIT     = 400_000;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_DUTY,
    RX_SPARSE
  } rx_pattern_e;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [23:0]           s_tdata;   // buffer_offset[13:0], write_byte[21:14]
  logic                  s_tuser;   // opcode
  logic                  m_tvalid;
  logic                  m_tready;
  logic [47:0]           m_tdata;   // pixel_x[9:0], pixel_y[19:10], pixel_color[43:20]
  logic                  m_tlast;   // frame_last

  raster_scoreboard sb;
  bit               rx_stalls;
  int unsigned      cycles;

  scaled_2bpp_video_scanout_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // both streams are observed at the rising edge; inputs are noted before outputs
  // are checked, though a tick can never come out on its own transfer edge
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_transfer(opcode_t'(s_tuser), s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_pixel(m_tdata, m_tlast);
  end

  // receiver: always ready until the random phases, then it switches between
  // short stretches of always ready, coin flips, a fixed duty cycle and rare ready
  initial begin : receiver
    rx_pattern_e pattern;
    int unsigned left;
    int unsigned phase;
    pattern = RX_ALWAYS;
    left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (!rx_stalls) begin
        m_tready <= 1'b1;
      end else begin
        if (left == 0) begin
          pattern = rx_pattern_e'($urandom_range(RX_ALWAYS, RX_SPARSE));
          left = $urandom_range(8, 64);
        end
        left--;
        phase++;
        case (pattern)
          RX_ALWAYS: m_tready <= 1'b1;
          RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
          RX_DUTY:   m_tready <= (phase % 5) < 3;
          default:   m_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // one transfer on the input stream; valid stays high into the next call
  task automatic send_item(input opcode_t op, input logic [RAM_ADDR_W-1:0] off,
                           input logic [BYTE_W-1:0] val);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, val, off};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic idle_input(input int unsigned n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // wait out every pending pixel, then the pipeline depth for trailing writes
  task automatic drain();
    idle_input(1);
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write followed by a readback of the same register
  task automatic write_palette(input palette_reg_e idx, input logic [APB_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * idx);
    pwdata  <= value;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_color(idx, value);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_register(idx, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_palette(input logic [APB_DATA_W-1:0] c0, input logic [APB_DATA_W-1:0] c1,
                                 input logic [APB_DATA_W-1:0] c2, input logic [APB_DATA_W-1:0] c3);
    write_palette(PAL_COLOR0, c0);
    write_palette(PAL_COLOR1, c1);
    write_palette(PAL_COLOR2, c2);
    write_palette(PAL_COLOR3, c3);
  endtask

  // random traffic in bursts; most writes land on bytes the scan is about to read
  task automatic random_items(input int unsigned count);
    int unsigned           burst;
    int unsigned           pick;
    logic [RAM_ADDR_W-1:0] off;
    logic [BYTE_W-1:0]     val;
    burst = 0;
    repeat (count) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 6));
      end
      burst--;
      pick = $urandom_range(0, 99);
      off  = RAM_ADDR_W'($urandom);
      val  = BYTE_W'($urandom);
      if (pick < 55) begin
        send_item(OP_TICK, off, val);
      end else begin
        if (pick < 85) off = sb.upcoming_offset($urandom_range(0, 12));
        else if (pick < 92) off = RAM_ADDR_W'($urandom_range(VISIBLE_BYTES, RAM_DEPTH - 1));
        send_item(OP_WRITE, off, val);
      end
    end
  endtask

  initial begin : run_limit
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("scaled_2bpp_video_scanout_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned t;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    s_tvalid  = 1'b0;
    s_tuser   = OP_WRITE;
    s_tdata   = '0;
    m_tready  = 1'b0;
    rx_stalls = 1'b0;
    rst       = 1'b1;
    sb = new();
    sb.clear();
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed part on the reset palette; the first transfer waits out the
    // clearing sweep because s_tready is low until it finishes
    send_item(OP_WRITE, 14'd0, 8'b00_01_10_11);      // all four codes, leftmost in bits 7:6
    send_item(OP_WRITE, 14'd1, 8'b11_10_01_00);
    send_item(OP_WRITE, 14'd63, 8'hC6);              // end of the first source row
    send_item(OP_WRITE, RAM_ADDR_W'(VISIBLE_BYTES - 1), 8'h5A);  // last visible byte
    send_item(OP_WRITE, RAM_ADDR_W'(VISIBLE_BYTES), 8'hFF);      // stored but never shown
    send_item(OP_WRITE, 14'h3FFF, 8'hFF);            // highest offset
    for (t = 0; t < 12; t++)                         // each source pixel repeated three times
      send_item(OP_TICK, (t % 2) ? 14'h3FFF : 14'h0, (t % 2) ? 8'hFF : 8'h00);
    send_item(OP_WRITE, 14'd1, 8'h1B);               // overwrite right before it is read
    send_item(OP_TICK, 14'h0, 8'h00);
    send_item(OP_WRITE, 14'd1, 8'hC0);
    send_item(OP_TICK, 14'h3FFF, 8'hFF);
    send_item(OP_TICK, 14'h0, 8'h00);
    drain();

    // extremes, plus a value whose upper byte must be dropped
    program_palette(32'h00FF_FFFF, 32'h0000_0000, 32'hFF12_3456, 32'h0080_0001);

    // ticks back to back along the first output row, over freshly written
    // bytes of the first source row
    repeat (48)
      send_item(OP_WRITE, RAM_ADDR_W'($urandom_range(0, 63)), BYTE_W'($urandom));
    for (t = 0; t < FULL_RATE_TICKS; t++) begin
      if (t % 50 == 25)
        send_item(OP_WRITE, sb.upcoming_offset($urandom_range(1, 40)), BYTE_W'($urandom));
      send_item(OP_TICK, RAM_ADDR_W'($urandom), BYTE_W'($urandom));
    end
    drain();

    // random phases with stalls on both sides, each under its own palette
    rx_stalls = 1'b1;
    for (t = 0; t < 4; t++) begin
      case (t)
        0: program_palette(32'h0000_0000, 32'h00FF_FFFF, $urandom, $urandom);
        1: program_palette($urandom, $urandom, $urandom, $urandom);
        2: program_palette(32'h00FF_FFFF, 32'h0000_0000, 32'h00FF_FFFF, 32'h0000_0000);
        default: program_palette({8'hA5, PAL0_RESET}, {8'hFF, PAL1_RESET},
                                 {8'h01, PAL2_RESET}, {8'h80, PAL3_RESET});
      endcase
      random_items(330);
      drain();
    end

    sb.finish();
    if (sb.failures == 0) begin
      $display("scaled_2bpp_video_scanout_unit verification clean");
    end else begin
      $display("scaled_2bpp_video_scanout_unit verification failed");
    end
    $finish;
  end
endmodule
